// File: design/mpme_pkg.sv
// Shared types, field widths and quantum-number helpers for the pair matrix element core.
`timescale 1ns / 1ps

package mpme_pkg;

  // Item kind carried on the slave-side tuser
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_e;

  localparam int IDX_W      = 10;
  localparam int WEIGHT_W   = 32;
  localparam int STATE_W    = 14;
  localparam int MOM_W      = 4;
  localparam int ELEM_W     = 36;
  // largest transfer is 3 * 30^2 = 2700
  localparam int M_W        = 12;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 40;

  localparam int SPIN_BIT = 12;
  localparam int ISO_BIT  = 13;

  // Spin/isospin overlaps of the direct ordering (p q | r s)
  typedef struct packed {
    logic id_s;
    logic id_t;
    logic ex_s;
    logic ex_t;
  } delta_t;

  // Squared momentum transfer, sum over axes of (a - b - c + d)^2
  function automatic logic [M_W-1:0] transfer(input logic [STATE_W-1:0] a,
                                               input logic [STATE_W-1:0] b,
                                               input logic [STATE_W-1:0] c,
                                               input logic [STATE_W-1:0] d);
    logic signed [5:0]  t;
    logic signed [11:0] sq;
    logic [M_W-1:0]     acc;
    acc = '0;
    for (int ax = 0; ax < 3; ax++) begin
      t = 6'($signed(a[MOM_W*ax +: MOM_W])) - 6'($signed(b[MOM_W*ax +: MOM_W]))
        - 6'($signed(c[MOM_W*ax +: MOM_W])) + 6'($signed(d[MOM_W*ax +: MOM_W]));
      sq  = 12'(t) * 12'(t);
      acc = acc + M_W'(unsigned'(sq));
    end
    return acc;
  endfunction

  // p + q == r + s on every axis
  function automatic logic conserved(input logic [STATE_W-1:0] p,
                                     input logic [STATE_W-1:0] q,
                                     input logic [STATE_W-1:0] r,
                                     input logic [STATE_W-1:0] s);
    logic ok;
    ok = 1'b1;
    for (int ax = 0; ax < 3; ax++) begin
      if (5'($signed(p[MOM_W*ax +: MOM_W])) + 5'($signed(q[MOM_W*ax +: MOM_W])) !=
          5'($signed(r[MOM_W*ax +: MOM_W])) + 5'($signed(s[MOM_W*ax +: MOM_W]))) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic delta_t deltas(input logic [STATE_W-1:0] p,
                                    input logic [STATE_W-1:0] q,
                                    input logic [STATE_W-1:0] r,
                                    input logic [STATE_W-1:0] s);
    delta_t dl;
    dl.id_s = (p[SPIN_BIT] == r[SPIN_BIT]) && (q[SPIN_BIT] == s[SPIN_BIT]);
    dl.id_t = (p[ISO_BIT] == r[ISO_BIT]) && (q[ISO_BIT] == s[ISO_BIT]);
    dl.ex_s = (p[SPIN_BIT] == s[SPIN_BIT]) && (q[SPIN_BIT] == r[SPIN_BIT]);
    dl.ex_t = (p[ISO_BIT] == s[ISO_BIT]) && (q[ISO_BIT] == r[ISO_BIT]);
    return dl;
  endfunction

endpackage

// File: design/minnesota_pair_matrix_element_core.sv
// Minnesota-potential antisymmetrized pair matrix element: strength table and evaluation pipe.
//
// Usage:
//   Slave stream carries one item per transfer. tuser = kind. A load item
//   (kind 0) writes A and B strengths into table entry table_index; loads at or
//   beyond TABLE_DEPTH are dropped. An evaluate item (kind 1) yields exactly one
//   result on the master stream; a load yields none.
//   Master stream tdata = 4 * <pq|V|rs>_antisym, tuser = momentum-conserved flag.
//   Non-conserving quadruples return zero with the flag low.
// Path: an accepted evaluate passes the table read, the term sum and the
//   difference register, in that order, before it shows tvalid.
// Throughput: one item per cycle unless stalled, loads and evaluates mixed
//   freely. The two table reads of an evaluate use the two read ports of one
//   memory at the accept edge, and a load writes at its own accept edge, so a
//   load followed directly by an evaluate of the same entry already sees the new value.
// Reset: pipeline valids clear; the table keeps its contents and must be
//   loaded before any entry is evaluated. No clearing pass.
// Stall: each stage holds while the next one is full and cannot move on; s_axis_tready
//   falls only once the output register and both inner stages are occupied.
`timescale 1ns / 1ps

module minnesota_pair_matrix_element_core
  import mpme_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [9:0] table_index, [41:10] central_weight, [73:42] exchange_weight,
  // [87:74] state_p, [101:88] state_q, [115:102] state_r, [129:116] state_s, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] kind
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [35:0] matrix_element, [39:36] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] momentum_conserved
  output logic [0:0]            m_axis_tuser
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int XW = M_W + 1;

  // ---------------- input fields
  kind_e                       kind;
  logic [IDX_W-1:0]            table_index;
  logic [WEIGHT_W-1:0]         central_weight;
  logic [WEIGHT_W-1:0]         exchange_weight;
  logic [STATE_W-1:0]          state_p, state_q, state_r, state_s;

  assign kind            = kind_e'(s_axis_tuser[0]);
  assign table_index     = s_axis_tdata[9:0];
  assign central_weight  = s_axis_tdata[41:10];
  assign exchange_weight = s_axis_tdata[73:42];
  assign state_p         = s_axis_tdata[87:74];
  assign state_q         = s_axis_tdata[101:88];
  assign state_r         = s_axis_tdata[115:102];
  assign state_s         = s_axis_tdata[129:116];

  // ---------------- handshake
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic rdy_out, rdy2, rdy1;
  logic in_xfer, load_xfer, eval_xfer;

  assign rdy_out = !out_valid_q || m_axis_tready;
  assign rdy2    = !s2_valid_q || rdy_out;
  assign rdy1    = !s1_valid_q || rdy2;

  assign s_axis_tready = rdy1;
  assign in_xfer       = s_axis_tvalid && rdy1;
  assign load_xfer     = in_xfer && (kind == KIND_LOAD);
  assign eval_xfer     = in_xfer && (kind == KIND_EVAL);

  // ---------------- addresses
  logic [XW-1:0] widx_ext, mdir_ext, mexc_ext;
  logic          load_ok, dir_ok, exc_ok;

  assign widx_ext = XW'(table_index);
  assign mdir_ext = XW'(transfer(state_p, state_q, state_r, state_s));
  assign mexc_ext = XW'(transfer(state_p, state_q, state_s, state_r));
  assign load_ok  = widx_ext < XW'(TABLE_DEPTH);
  assign dir_ok   = mdir_ext < XW'(TABLE_DEPTH);
  assign exc_ok   = mexc_ext < XW'(TABLE_DEPTH);

  // ---------------- strength table: {B, A} per entry, one write, two reads
  logic [2*WEIGHT_W-1:0] table_mem [TABLE_DEPTH];
  logic [2*WEIGHT_W-1:0] rd_dir_q, rd_exc_q;

  always_ff @(posedge clk_i) begin
    if (load_xfer && load_ok) begin
      table_mem[widx_ext[AW-1:0]] <= {exchange_weight, central_weight};
    end
    if (eval_xfer) begin
      rd_dir_q <= table_mem[mdir_ext[AW-1:0]];
      rd_exc_q <= table_mem[mexc_ext[AW-1:0]];
    end
  end

  // ---------------- stage 1: flags beside the table read
  logic   s1_dir_ok_q, s1_exc_ok_q, s1_cons_q;
  delta_t s1_delta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rdy1) begin
      s1_valid_q <= eval_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_xfer) begin
      s1_dir_ok_q <= dir_ok;
      s1_exc_ok_q <= exc_ok;
      s1_cons_q   <= conserved(state_p, state_q, state_r, state_s);
      s1_delta_q  <= deltas(state_p, state_q, state_r, state_s);
    end
  end

  // ---------------- stage 2: direct and exchanged terms
  logic signed [WEIGHT_W-1:0] a_dir, b_dir, a_exc, b_exc;
  logic signed [ELEM_W-1:0]   a2_dir, bx_dir, a2_exc, bx_exc;
  logic signed [ELEM_W-1:0]   d_dir, d_exc;
  logic signed [ELEM_W-1:0]   s2_dir_q, s2_exc_q;
  logic                       s2_cons_q;
  delta_t                     dl;

  always_comb begin
    dl     = s1_delta_q;
    // out-of-range transfer reads as a zero entry
    a_dir  = s1_dir_ok_q ? $signed(rd_dir_q[WEIGHT_W-1:0])          : '0;
    b_dir  = s1_dir_ok_q ? $signed(rd_dir_q[2*WEIGHT_W-1:WEIGHT_W]) : '0;
    a_exc  = s1_exc_ok_q ? $signed(rd_exc_q[WEIGHT_W-1:0])          : '0;
    b_exc  = s1_exc_ok_q ? $signed(rd_exc_q[2*WEIGHT_W-1:WEIGHT_W]) : '0;
    a2_dir = ELEM_W'(a_dir) <<< 1;
    bx_dir = ELEM_W'(b_dir);
    a2_exc = ELEM_W'(a_exc) <<< 1;
    bx_exc = ELEM_W'(b_exc);
    // D = 2A*IsIt + B*PsIt - 2A*PsPt - B*IsPt
    d_dir  = ((dl.id_s && dl.id_t) ? a2_dir : '0)
           + ((dl.ex_s && dl.id_t) ? bx_dir : '0)
           - ((dl.ex_s && dl.ex_t) ? a2_dir : '0)
           - ((dl.id_s && dl.ex_t) ? bx_dir : '0);
    // r and s swapped: identity and exchange overlaps trade places
    d_exc  = ((dl.ex_s && dl.ex_t) ? a2_exc : '0)
           + ((dl.id_s && dl.ex_t) ? bx_exc : '0)
           - ((dl.id_s && dl.id_t) ? a2_exc : '0)
           - ((dl.ex_s && dl.id_t) ? bx_exc : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (rdy2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_valid_q) begin
      s2_dir_q  <= d_dir;
      s2_exc_q  <= d_exc;
      s2_cons_q <= s1_cons_q;
    end
  end

  // ---------------- output register
  logic signed [ELEM_W-1:0] out_elem_d, out_elem_q;
  logic                     out_cons_q;

  assign out_elem_d = s2_cons_q ? (s2_dir_q - s2_exc_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy_out) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && s2_valid_q) begin
      out_elem_q <= out_elem_d;
      out_cons_q <= s2_cons_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(unsigned'(out_elem_q));
  assign m_axis_tuser  = out_cons_q;

endmodule

// File: design/mpme_checker.sv
// Port-level checks for the pair matrix element core, bound to the top level.
`timescale 1ns / 1ps

module mpme_checker
  import mpme_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [0:0]            s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]            m_axis_tuser
);

  logic eval_xfer;
  assign eval_xfer = s_axis_tvalid && s_axis_tready && (kind_e'(s_axis_tuser[0]) == KIND_EVAL);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // empty output register never back-pressures the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output register empty");

  // non-conserving quadruple gives a zero element
  a_zero_nc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[ELEM_W-1:0] == '0)
    else $error("nonzero element without momentum conservation");

  // evaluate reaches the output while the receiver keeps up
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_xfer ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("evaluate result late");

endmodule

bind minnesota_pair_matrix_element_core mpme_checker u_mpme_checker (.*);
